@@ hw/rtl/bklz_pkg.sv @@
// Shared types and constants of the backward LZ bit unpacker.
package bklz_pkg;

   localparam int WIN_BITS  = 12;
   localparam int WIN_DEPTH = 4096;

   typedef enum logic [1:0] {
      CMD_SIZE   = 2'd0,
      CMD_SEED   = 2'd1,
      CMD_SOURCE = 2'd2,
      CMD_PULL   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_HDR_A     = 4'd0,
      PH_HDR_B     = 4'd1,
      PH_CODE      = 4'd2,
      PH_LIT_LEN3  = 4'd3,
      PH_NEAR_DIST = 4'd4,
      PH_LIT_LEN8  = 4'd5,
      PH_LONG_LEN  = 4'd6,
      PH_LONG_DIST = 4'd7,
      PH_DIST10    = 4'd8,
      PH_DIST9     = 4'd9,
      PH_LIT_BYTE  = 4'd10,
      PH_COPY      = 4'd11,
      PH_DONE      = 4'd12
   } phase_type;

   typedef enum logic [2:0] {
      ENG_CLEAR,
      ENG_IDLE,
      ENG_PULL,
      ENG_COPY,
      ENG_RESP
   } eng_state_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] word;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       need_word;
      logic       done_res;
      logic       crc_ok;
      logic       size_error;
   } rsp_type;

endpackage

@@ hw/rtl/bklz_req_fifo.sv @@
// Two-entry request queue between the accepting front and the decode engine.
module bklz_req_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bklz_pkg::req_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output bklz_pkg::req_type pop_data
);

   bklz_pkg::req_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/bklz_engine.sv @@
// Decode engine: header handling, serial bit decoding and the history window.
module bklz_engine #(
   parameter int SIZE_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       capacity,
   input  logic              fifo_empty,
   input  bklz_pkg::req_type fifo_data,
   output logic              fifo_pop,
   input  logic              slot_free,
   output logic              res_valid,
   output bklz_pkg::rsp_type res,
   output logic              clearing
);

   logic [7:0] mem [bklz_pkg::WIN_DEPTH];
   logic [7:0] rdata_ff;
   logic       mem_we;
   logic [bklz_pkg::WIN_BITS-1:0] mem_wa, rd_addr;
   logic [7:0] mem_wd;

   bklz_pkg::eng_state_type state_ff, state_in;
   bklz_pkg::phase_type     ph_ff, ph_in;
   logic [bklz_pkg::WIN_BITS-1:0] clr_ff, clr_in;
   logic [bklz_pkg::WIN_BITS-1:0] wp_ff, wp_in;
   logic [bklz_pkg::WIN_BITS-1:0] dist_ff, dist_in;
   logic [31:0]          bitbuf_ff, bitbuf_in;
   logic                 fresh_ff, fresh_in;
   logic [31:0]          check_ff, check_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic [1:0]           hph_ff, hph_in;
   logic [11:0]          acc_ff, acc_in;
   logic [3:0]           left_ff, left_in;
   logic [8:0]           runleft_ff, runleft_in;
   logic                 lit_ff, lit_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 valid_ff, valid_in;
   logic                 need_ff, need_in;
   logic                 serr_ff, serr_in;

   logic        pull_stop, pull_copy, pull_dry, step_fin, step_emit;
   logic [11:0] acc_new;
   logic [3:0]  left_new;
   logic        done_now;

   assign clearing  = (state_ff == bklz_pkg::ENG_CLEAR);
   assign pull_stop = (hph_ff != 2'd3) || (ph_ff == bklz_pkg::PH_DONE);
   assign pull_copy = !pull_stop && (ph_ff == bklz_pkg::PH_COPY);
   assign pull_dry  = !pull_stop && !pull_copy && !fresh_ff && (bitbuf_ff[31:1] == 31'd0);
   assign acc_new   = {acc_ff[10:0], bitbuf_ff[0]};
   assign left_new  = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
   assign step_fin  = (left_new == 4'd0);
   assign step_emit = !pull_stop && !pull_copy && !pull_dry && step_fin
                      && (ph_ff == bklz_pkg::PH_LIT_BYTE);
   assign done_now  = (hph_ff == 2'd3) && (ph_ff == bklz_pkg::PH_DONE);
   assign rd_addr   = wp_ff - dist_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bklz_pkg::ENG_CLEAR: begin
            if (clr_ff == bklz_pkg::WIN_BITS'(bklz_pkg::WIN_DEPTH - 1)) begin
               state_in = bklz_pkg::ENG_IDLE;
            end
         end
         bklz_pkg::ENG_IDLE: begin
            if (!fifo_empty && slot_free) begin
               state_in = (fifo_data.command == bklz_pkg::CMD_PULL) ?
                          bklz_pkg::ENG_PULL : bklz_pkg::ENG_RESP;
            end
         end
         bklz_pkg::ENG_PULL: begin
            priority if (pull_stop || pull_dry || step_emit) begin
               state_in = bklz_pkg::ENG_RESP;
            end else if (pull_copy) begin
               state_in = bklz_pkg::ENG_COPY;
            end
         end
         bklz_pkg::ENG_COPY: state_in = bklz_pkg::ENG_RESP;
         bklz_pkg::ENG_RESP: state_in = bklz_pkg::ENG_IDLE;
         default:            state_in = bklz_pkg::ENG_IDLE;
      endcase
   end

   always_comb begin
      logic        start_now, emit_now, st_lit;
      logic [8:0]  st_len, n, rl;
      logic [11:0] st_dist;
      logic [7:0]  emit_byte;
      logic [31:0] len32, rem32;

      start_now = 1'b0;
      emit_now  = 1'b0;
      st_lit    = 1'b0;
      st_len    = 9'd0;
      st_dist   = 12'd0;
      emit_byte = 8'd0;
      n         = 9'd0;
      rl        = 9'd0;
      len32     = 32'd0;
      rem32     = 32'd0;

      ph_in      = ph_ff;
      clr_in     = clr_ff;
      wp_in      = wp_ff;
      dist_in    = dist_ff;
      bitbuf_in  = bitbuf_ff;
      fresh_in   = fresh_ff;
      check_in   = check_ff;
      rem_in     = rem_ff;
      hph_in     = hph_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      runleft_in = runleft_ff;
      lit_in     = lit_ff;
      byte_in    = byte_ff;
      valid_in   = valid_ff;
      need_in    = need_ff;
      serr_in    = serr_ff;
      mem_we     = 1'b0;
      mem_wa     = wp_ff;
      mem_wd     = 8'd0;
      fifo_pop   = 1'b0;
      res_valid  = 1'b0;

      unique case (state_ff)
         bklz_pkg::ENG_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         bklz_pkg::ENG_IDLE: begin
            if (!fifo_empty && slot_free) begin
               fifo_pop = 1'b1;
               byte_in  = 8'd0;
               valid_in = 1'b0;
               need_in  = 1'b0;
               serr_in  = 1'b0;
               unique case (fifo_data.command)
                  bklz_pkg::CMD_SIZE: begin
                     bitbuf_in  = 32'd0;
                     fresh_in   = 1'b0;
                     check_in   = 32'd0;
                     runleft_in = 9'd0;
                     dist_in    = '0;
                     lit_in     = 1'b0;
                     ph_in      = bklz_pkg::PH_HDR_A;
                     acc_in     = 12'd0;
                     left_in    = 4'd1;
                     if (fifo_data.word > {8'd0, capacity}
                         || fifo_data.word[31:SIZE_BITS] != '0) begin
                        serr_in = 1'b1;
                        rem_in  = '0;
                        hph_in  = 2'd0;
                     end else begin
                        rem_in = fifo_data.word[SIZE_BITS-1:0];
                        hph_in = 2'd1;
                     end
                  end
                  bklz_pkg::CMD_SEED: begin
                     if (hph_ff == 2'd1) begin
                        check_in = fifo_data.word;
                        hph_in   = 2'd2;
                     end
                  end
                  bklz_pkg::CMD_SOURCE: begin
                     priority if (hph_ff == 2'd2) begin
                        check_in  = check_ff ^ fifo_data.word;
                        bitbuf_in = fifo_data.word;
                        fresh_in  = 1'b0;
                        hph_in    = 2'd3;
                     end else if (hph_ff == 2'd3 && ph_ff != bklz_pkg::PH_DONE
                                  && !fresh_ff && bitbuf_ff[31:1] == 31'd0) begin
                        check_in  = check_ff ^ fifo_data.word;
                        bitbuf_in = fifo_data.word;
                        fresh_in  = 1'b1;
                     end
                  end
                  bklz_pkg::CMD_PULL: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         bklz_pkg::ENG_PULL: begin
            priority if (pull_stop || pull_copy) begin
            end else if (pull_dry) begin
               need_in = 1'b1;
            end else begin
               bitbuf_in = {fresh_ff, bitbuf_ff[31:1]};
               fresh_in  = 1'b0;
               acc_in    = acc_new;
               left_in   = left_new;
               if (step_fin) begin
                  unique case (ph_ff)
                     bklz_pkg::PH_LIT_BYTE: begin
                        emit_now  = 1'b1;
                        emit_byte = acc_new[7:0];
                     end
                     bklz_pkg::PH_HDR_A: begin
                        ph_in   = acc_new[0] ? bklz_pkg::PH_CODE : bklz_pkg::PH_HDR_B;
                        acc_in  = 12'd0;
                        left_in = acc_new[0] ? 4'd2 : 4'd1;
                     end
                     bklz_pkg::PH_HDR_B: begin
                        ph_in   = acc_new[0] ? bklz_pkg::PH_NEAR_DIST : bklz_pkg::PH_LIT_LEN3;
                        acc_in  = 12'd0;
                        left_in = acc_new[0] ? 4'd8 : 4'd3;
                     end
                     bklz_pkg::PH_CODE: begin
                        acc_in = 12'd0;
                        priority if (acc_new == 12'd3) begin
                           ph_in   = bklz_pkg::PH_LIT_LEN8;
                           left_in = 4'd8;
                        end else if (acc_new == 12'd2) begin
                           ph_in   = bklz_pkg::PH_LONG_LEN;
                           left_in = 4'd8;
                        end else if (acc_new == 12'd1) begin
                           ph_in   = bklz_pkg::PH_DIST10;
                           left_in = 4'd10;
                        end else begin
                           ph_in   = bklz_pkg::PH_DIST9;
                           left_in = 4'd9;
                        end
                     end
                     bklz_pkg::PH_LIT_LEN3: begin
                        start_now = 1'b1;
                        st_len    = {6'd0, acc_new[2:0]} + 9'd1;
                        st_lit    = 1'b1;
                     end
                     bklz_pkg::PH_NEAR_DIST: begin
                        start_now = 1'b1;
                        st_len    = 9'd2;
                        st_dist   = acc_new;
                     end
                     bklz_pkg::PH_LIT_LEN8: begin
                        start_now = 1'b1;
                        st_len    = {1'b0, acc_new[7:0]} + 9'd9;
                        st_lit    = 1'b1;
                     end
                     bklz_pkg::PH_LONG_LEN: begin
                        runleft_in = {1'b0, acc_new[7:0]} + 9'd1;
                        ph_in      = bklz_pkg::PH_LONG_DIST;
                        acc_in     = 12'd0;
                        left_in    = 4'd12;
                     end
                     bklz_pkg::PH_LONG_DIST: begin
                        start_now = 1'b1;
                        st_len    = runleft_ff;
                        st_dist   = acc_new;
                     end
                     bklz_pkg::PH_DIST10: begin
                        start_now = 1'b1;
                        st_len    = 9'd4;
                        st_dist   = acc_new;
                     end
                     bklz_pkg::PH_DIST9: begin
                        start_now = 1'b1;
                        st_len    = 9'd3;
                        st_dist   = acc_new;
                     end
                     default: ph_in = bklz_pkg::PH_DONE;
                  endcase
               end
            end
         end
         bklz_pkg::ENG_COPY: begin
            emit_now  = 1'b1;
            emit_byte = rdata_ff;
         end
         bklz_pkg::ENG_RESP: res_valid = 1'b1;
         default: begin
         end
      endcase

      if (start_now) begin
         len32      = {23'd0, st_len};
         rem32      = 32'(rem_ff);
         n          = (len32 > rem32) ? rem32[8:0] : st_len;
         rem_in     = rem_ff - SIZE_BITS'(n);
         runleft_in = n;
         dist_in    = st_dist;
         lit_in     = st_lit;
         if (n == 9'd0) begin
            ph_in = bklz_pkg::PH_DONE;
         end else if (st_lit) begin
            ph_in   = bklz_pkg::PH_LIT_BYTE;
            acc_in  = 12'd0;
            left_in = 4'd8;
         end else begin
            ph_in = bklz_pkg::PH_COPY;
         end
      end

      if (emit_now) begin
         mem_we     = 1'b1;
         mem_wa     = wp_ff;
         mem_wd     = emit_byte;
         wp_in      = wp_ff + 1'b1;
         byte_in    = emit_byte;
         valid_in   = 1'b1;
         rl         = (runleft_ff != 9'd0) ? runleft_ff - 9'd1 : 9'd0;
         runleft_in = rl;
         if (rl == 9'd0) begin
            if (rem_ff == '0) begin
               ph_in = bklz_pkg::PH_DONE;
            end else begin
               ph_in   = bklz_pkg::PH_HDR_A;
               acc_in  = 12'd0;
               left_in = 4'd1;
            end
         end else if (lit_ff) begin
            ph_in   = bklz_pkg::PH_LIT_BYTE;
            acc_in  = 12'd0;
            left_in = 4'd8;
         end
      end
   end

   always_comb begin
      res.out_byte   = byte_ff;
      res.byte_valid = valid_ff;
      res.need_word  = need_ff;
      res.done_res   = done_now;
      res.crc_ok     = done_now && (check_ff == 32'd0);
      res.size_error = serr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bklz_pkg::ENG_CLEAR;
         ph_ff      <= bklz_pkg::PH_HDR_A;
         clr_ff     <= '0;
         wp_ff      <= '0;
         dist_ff    <= '0;
         bitbuf_ff  <= 32'd0;
         fresh_ff   <= 1'b0;
         check_ff   <= 32'd0;
         rem_ff     <= '0;
         hph_ff     <= 2'd0;
         acc_ff     <= 12'd0;
         left_ff    <= 4'd0;
         runleft_ff <= 9'd0;
         lit_ff     <= 1'b0;
         valid_ff   <= 1'b0;
         need_ff    <= 1'b0;
         serr_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ph_ff      <= ph_in;
         clr_ff     <= clr_in;
         wp_ff      <= wp_in;
         dist_ff    <= dist_in;
         bitbuf_ff  <= bitbuf_in;
         fresh_ff   <= fresh_in;
         check_ff   <= check_in;
         rem_ff     <= rem_in;
         hph_ff     <= hph_in;
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         runleft_ff <= runleft_in;
         lit_ff     <= lit_in;
         valid_ff   <= valid_in;
         need_ff    <= need_in;
         serr_ff    <= serr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   a_res_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> slot_free) else $error("result produced while the slot is full");

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !fifo_pop) else $error("request taken during the window clear");

   a_copy_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bklz_pkg::ENG_PULL && pull_copy) |=> state_ff == bklz_pkg::ENG_COPY)
      else $error("window read not followed by the copy step");

   a_byte_only_on_emit: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.byte_valid) |-> !res.need_word)
      else $error("byte and need flag in one response");

endmodule

@@ hw/rtl/backward_lz_bit_unpacker_unit.sv @@
// Top level: request queue, decode engine, response slot and capacity register.
// A word request passes from the idle state through the response state into the response slot.
// A pull decodes bits serially until a literal byte is complete, a source word is needed
// or the stream ends; a copied byte passes through the copy state before the response state.
// The engine holds one request at a time and starts the next once the slot is empty.
// Synchronous reset clears control state, then a clearing pass zeroes every window entry;
// req_full stays high during that pass.
module backward_lz_bit_unpacker_unit #(
   parameter int SIZE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_need_word,
   output logic        rsp_done_res,
   output logic        rsp_crc_ok,
   output logic        rsp_size_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);

   bklz_pkg::req_type push_data, fifo_data;
   bklz_pkg::rsp_type res, slot_ff;
   logic fifo_full, fifo_empty, fifo_pop, res_valid, clearing;
   logic slot_valid_ff, slot_valid_in;
   logic [23:0] capacity_ff;

   assign push_data.command = bklz_pkg::cmd_type'(req_command);
   assign push_data.word    = req_word;
   assign req_full          = fifo_full || clearing;
   assign csr_ready         = 1'b1;

   bklz_req_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !clearing),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .pop_data  (fifo_data)
   );

   bklz_engine #(.SIZE_BITS(SIZE_BITS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_data),
      .fifo_pop   (fifo_pop),
      .slot_free  (!slot_valid_ff),
      .res_valid  (res_valid),
      .res        (res),
      .clearing   (clearing)
   );

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (rsp_pop && slot_valid_ff) begin
         slot_valid_in = 1'b0;
      end
      if (res_valid) begin
         slot_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         capacity_ff   <= 24'hFFFFFF;
      end else begin
         slot_valid_ff <= slot_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         slot_ff <= res;
      end
   end

   assign rsp_empty      = !slot_valid_ff;
   assign rsp_out_byte   = slot_ff.out_byte;
   assign rsp_byte_valid = slot_ff.byte_valid;
   assign rsp_need_word  = slot_ff.need_word;
   assign rsp_done_res   = slot_ff.done_res;
   assign rsp_crc_ok     = slot_ff.crc_ok;
   assign rsp_size_error = slot_ff.size_error;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the backward LZ bit unpacker: scoreboard with predictor and drivers.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   class unpack_scoreboard;
      logic [23:0] capacity;
      logic [31:0] bit_buffer;
      logic        word_fresh;
      logic [31:0] check_value;
      logic [23:0] remaining;
      int          header_phase;
      bklz_pkg::phase_type phase;
      logic [11:0] field_accum;
      int          field_bits_left;
      logic [8:0]  run_left;
      logic [11:0] copy_distance;
      logic        run_is_literal;
      logic [7:0]  history [bklz_pkg::WIN_DEPTH];
      logic [11:0] write_pointer;
      bklz_pkg::rsp_type expected_q [$];
      int          errors;

      function new();
         capacity = 24'hFFFFFF;
         bit_buffer = '0;
         word_fresh = 1'b0;
         check_value = '0;
         remaining = '0;
         header_phase = 0;
         phase = bklz_pkg::PH_HDR_A;
         field_accum = '0;
         field_bits_left = 0;
         run_left = '0;
         copy_distance = '0;
         run_is_literal = 1'b0;
         foreach (history[i]) history[i] = 8'h00;
         write_pointer = '0;
         errors = 0;
      endfunction

      function bit buffer_dry();
         return !word_fresh && (bit_buffer >> 1) == 0;
      endfunction

      function bit stream_done();
         return header_phase == 3 && phase == bklz_pkg::PH_DONE;
      endfunction

      function void arm(bklz_pkg::phase_type p, int nbits);
         phase = p;
         field_accum = '0;
         field_bits_left = nbits;
      endfunction

      function logic take_bit();
         logic b;
         b = bit_buffer[0];
         bit_buffer = bit_buffer >> 1;
         if (word_fresh) begin
            bit_buffer[31] = 1'b1;
            word_fresh = 1'b0;
         end
         return b;
      endfunction

      function void start_run(int unsigned len, bit literal, logic [11:0] distance);
         int unsigned n;
         n = (len > remaining) ? remaining : len;
         remaining = remaining - n;
         run_left = n[8:0];
         copy_distance = distance;
         run_is_literal = literal;
         if (run_left == 0) begin
            phase = bklz_pkg::PH_DONE;
         end else if (literal) begin
            arm(bklz_pkg::PH_LIT_BYTE, 8);
         end else begin
            phase = bklz_pkg::PH_COPY;
         end
      endfunction

      function void emit(logic [7:0] b);
         history[write_pointer] = b;
         write_pointer = write_pointer + 1;
      endfunction

      function void after_byte();
         if (run_left > 0) run_left = run_left - 1;
         if (run_left == 0) begin
            if (remaining == 0) phase = bklz_pkg::PH_DONE;
            else arm(bklz_pkg::PH_HDR_A, 1);
         end else if (run_is_literal) begin
            arm(bklz_pkg::PH_LIT_BYTE, 8);
         end
      endfunction

      function void finish_field(logic [11:0] v);
         case (phase)
            bklz_pkg::PH_HDR_A: begin
               if (v[0]) arm(bklz_pkg::PH_CODE, 2); else arm(bklz_pkg::PH_HDR_B, 1);
            end
            bklz_pkg::PH_HDR_B: begin
               if (v[0]) arm(bklz_pkg::PH_NEAR_DIST, 8);
               else arm(bklz_pkg::PH_LIT_LEN3, 3);
            end
            bklz_pkg::PH_CODE: begin
               if (v == 3) arm(bklz_pkg::PH_LIT_LEN8, 8);
               else if (v == 2) arm(bklz_pkg::PH_LONG_LEN, 8);
               else if (v == 1) arm(bklz_pkg::PH_DIST10, 10);
               else arm(bklz_pkg::PH_DIST9, 9);
            end
            bklz_pkg::PH_LIT_LEN3: start_run(v + 1, 1'b1, '0);
            bklz_pkg::PH_NEAR_DIST: start_run(2, 1'b0, v);
            bklz_pkg::PH_LIT_LEN8: start_run(v + 9, 1'b1, '0);
            bklz_pkg::PH_LONG_LEN: begin
               run_left = {1'b0, v[7:0]} + 9'd1;
               arm(bklz_pkg::PH_LONG_DIST, 12);
            end
            bklz_pkg::PH_LONG_DIST: start_run(run_left, 1'b0, v);
            bklz_pkg::PH_DIST10: start_run(4, 1'b0, v);
            bklz_pkg::PH_DIST9: start_run(3, 1'b0, v);
            default: phase = bklz_pkg::PH_DONE;
         endcase
      endfunction

      function void note_request(bklz_pkg::cmd_type cmd, logic [31:0] word);
         bklz_pkg::rsp_type r;
         r = '0;
         case (cmd)
            bklz_pkg::CMD_SIZE: begin
               bit_buffer = '0;
               word_fresh = 1'b0;
               check_value = '0;
               run_left = '0;
               copy_distance = '0;
               run_is_literal = 1'b0;
               arm(bklz_pkg::PH_HDR_A, 1);
               if (word > {8'h00, capacity} || word > 32'h00FFFFFF) begin
                  r.size_error = 1'b1;
                  remaining = '0;
                  header_phase = 0;
               end else begin
                  remaining = word[23:0];
                  header_phase = 1;
               end
            end
            bklz_pkg::CMD_SEED: begin
               if (header_phase == 1) begin
                  check_value = word;
                  header_phase = 2;
               end
            end
            bklz_pkg::CMD_SOURCE: begin
               if (header_phase == 2) begin
                  check_value ^= word;
                  bit_buffer = word;
                  word_fresh = 1'b0;
                  header_phase = 3;
               end else if (header_phase == 3 && phase != bklz_pkg::PH_DONE
                            && buffer_dry()) begin
                  check_value ^= word;
                  bit_buffer = word;
                  word_fresh = 1'b1;
               end
            end
            default: begin
               forever begin
                  if (header_phase != 3 || phase == bklz_pkg::PH_DONE) break;
                  if (phase == bklz_pkg::PH_COPY) begin
                     r.out_byte = history[write_pointer - copy_distance];
                     emit(r.out_byte);
                     after_byte();
                     r.byte_valid = 1'b1;
                     break;
                  end
                  if (buffer_dry()) begin
                     r.need_word = 1'b1;
                     break;
                  end
                  field_accum = {field_accum[10:0], take_bit()};
                  if (field_bits_left > 0) field_bits_left--;
                  if (field_bits_left != 0) continue;
                  if (phase == bklz_pkg::PH_LIT_BYTE) begin
                     r.out_byte = field_accum[7:0];
                     emit(r.out_byte);
                     after_byte();
                     r.byte_valid = 1'b1;
                     break;
                  end
                  finish_field(field_accum);
               end
            end
         endcase
         r.done_res = stream_done();
         r.crc_ok = r.done_res && check_value == 0;
         expected_q.push_back(r);
      endfunction

      function void check_response(bklz_pkg::rsp_type got);
         bklz_pkg::rsp_type exp;
         if (expected_q.size() == 0) begin
            $error("response with no request waiting");
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.out_byte !== exp.out_byte) begin
            $error("out_byte expected %0h got %0h", exp.out_byte, got.out_byte);
            errors++;
         end
         if (got.byte_valid !== exp.byte_valid) begin
            $error("byte_valid expected %0b got %0b", exp.byte_valid, got.byte_valid);
            errors++;
         end
         if (got.need_word !== exp.need_word) begin
            $error("need_word expected %0b got %0b", exp.need_word, got.need_word);
            errors++;
         end
         if (got.done_res !== exp.done_res) begin
            $error("done_res expected %0b got %0b", exp.done_res, got.done_res);
            errors++;
         end
         if (got.crc_ok !== exp.crc_ok) begin
            $error("crc_ok expected %0b got %0b", exp.crc_ok, got.crc_ok);
            errors++;
         end
         if (got.size_error !== exp.size_error) begin
            $error("size_error expected %0b got %0b", exp.size_error, got.size_error);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_command = bklz_pkg::CMD_PULL;
   logic [31:0] req_word = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_need_word;
   logic        rsp_done_res;
   logic        rsp_crc_ok;
   logic        rsp_size_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_data = '0;

   unpack_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   int request_count = 0;

   always #6 clock = ~clock;

   backward_lz_bit_unpacker_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_command(req_command), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_need_word(rsp_need_word), .rsp_done_res(rsp_done_res),
      .rsp_crc_ok(rsp_crc_ok), .rsp_size_error(rsp_size_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 20000) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The response side pops at random, with one long hold-off in the first capacity phase.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            board.check_response({rsp_out_byte, rsp_byte_valid, rsp_need_word,
                                  rsp_done_res, rsp_crc_ok, rsp_size_error});
         end
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_request(bklz_pkg::cmd_type cmd, logic [31:0] word);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_command <= cmd;
      req_word <= word;
      do @(posedge clock); while (req_full);
      board.note_request(cmd, word);
      request_count++;
   endtask

   task automatic drain_and_write_capacity(logic [23:0] value);
      req_push <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.capacity = value;
   endtask

   task automatic run_stream();
      logic [31:0] size_word;
      logic [31:0] first_word;
      bit          zero_check;
      int          pick;
      int          steps;
      pick = $urandom_range(99);
      if (pick < 5) size_word = 0;
      else if (pick < 10) size_word = $urandom();
      else if (pick < 15) size_word = $urandom_range(300, 40);
      else size_word = $urandom_range(40, 1);
      zero_check = $urandom_range(3) == 0;
      first_word = $urandom();
      send_request(bklz_pkg::CMD_SIZE, size_word);
      if (board.header_phase != 1) return;
      send_request(bklz_pkg::CMD_SEED, zero_check ? first_word : $urandom());
      send_request(bklz_pkg::CMD_SOURCE, first_word);
      steps = 0;
      while (!board.stream_done() && steps < 150) begin
         steps++;
         if ($urandom_range(99) < 6) begin
            send_request(bklz_pkg::cmd_type'($urandom_range(3)), $urandom());
         end else if (board.buffer_dry() && board.phase != bklz_pkg::PH_COPY) begin
            send_request(bklz_pkg::CMD_SOURCE, zero_check ? 32'h0 : $urandom());
         end else begin
            send_request(bklz_pkg::CMD_PULL, $urandom());
         end
      end
      if ($urandom_range(3) == 0) send_request(bklz_pkg::CMD_PULL, $urandom());
   endtask

   initial begin
      logic [23:0] capacity_values [4];
      int          start_count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Out-of-turn commands, rejected sizes and a zero-size stream.
      send_request(bklz_pkg::CMD_PULL, 32'h0);
      send_request(bklz_pkg::CMD_SEED, 32'hFFFFFFFF);
      send_request(bklz_pkg::CMD_SOURCE, 32'hFFFFFFFF);
      send_request(bklz_pkg::CMD_SIZE, 32'hFFFFFFFF);
      send_request(bklz_pkg::CMD_SIZE, 32'h01000000);
      send_request(bklz_pkg::CMD_SIZE, 32'h0);
      send_request(bklz_pkg::CMD_SOURCE, 32'h12345678);
      send_request(bklz_pkg::CMD_SEED, 32'h0);
      send_request(bklz_pkg::CMD_SOURCE, 32'h0);
      send_request(bklz_pkg::CMD_PULL, 32'h0);
      send_request(bklz_pkg::CMD_PULL, 32'h0);
      send_request(bklz_pkg::CMD_SOURCE, 32'h0);
      send_request(bklz_pkg::CMD_PULL, 32'h0);
      send_request(bklz_pkg::CMD_SIZE, 32'h00FFFFFF);
      send_request(bklz_pkg::CMD_SEED, 32'h0);
      send_request(bklz_pkg::CMD_SOURCE, 32'hFFFFFFFF);
      repeat (6) send_request(bklz_pkg::CMD_PULL, 32'hFFFFFFFF);

      capacity_values[0] = 24'hFFFFFF;
      capacity_values[1] = 24'h000000;
      capacity_values[2] = 24'd20;
      capacity_values[3] = $urandom();
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write_capacity(capacity_values[ph]);
         send_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 21 : 0;
         recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 21 : 0;
         if (ph == 0) hold_cycles = 400;
         start_count = request_count;
         while (request_count - start_count < 250) run_stream();
      end
      drain_and_write_capacity(24'hFFFFFF);
      start_count = request_count;
      while (request_count - start_count < 60) run_stream();

      req_push <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ backward_lz_bit_unpacker_unit.f @@
hw/rtl/bklz_pkg.sv
hw/rtl/bklz_req_fifo.sv
hw/rtl/bklz_engine.sv
hw/rtl/backward_lz_bit_unpacker_unit.sv
dv/testbench.sv
